FILE: sv/ept_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo probe tracker package
// Shared widths, codes, reset values and table and response word layouts.
// ----------------------------------------------------------------------------
package ept_pkg;

   localparam int RUNS_DEF  = 16;
   localparam int SLOTS_DEF = 8;

   localparam int OP_W    = 2;
   localparam int DEV_W   = 16;
   localparam int TIME_W  = 48;
   localparam int SEQ_W   = 16;
   localparam int KIND_W  = 3;
   localparam int LOST_W  = 4;
   localparam int RTT_W   = 32;
   localparam int MS_W    = 16;
   localparam int WIN_W   = 4;
   localparam int OFF_W   = 12;
   localparam int LIMIT_W = 26;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
   localparam logic [OP_W-1:0] OP_STOP   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
   localparam logic [OP_W-1:0] OP_REPLY  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_STARTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STOPPED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 1'd1;

   localparam logic [MS_W-1:0] INTERVAL_RST = 16'd1000;
   localparam logic [MS_W-1:0] TIMEOUT_RST  = 16'd2000;
   localparam logic [LIMIT_W-1:0] US_PER_MS = 26'd1000;

   typedef struct packed {
      logic [DEV_W-1:0]  dev;
      logic [WIN_W-1:0]  win;
      logic [OFF_W-1:0]  off;
      logic [TIME_W-1:0] due;
   } run_entry_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [TIME_W-1:0] stamp;
   } slot_entry_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DEV_W-1:0]  run_dev;
      logic [LOST_W-1:0] lost_count;
      logic              probe_sent;
      logic [SEQ_W-1:0]  probe_seq;
      logic [RTT_W-1:0]  rtt_us;
      logic              last;
   } rsp_word_type;

endpackage

FILE: sv/ept_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one command word: toggle, stop all, tick or echo reply.
// ----------------------------------------------------------------------------
interface ept_req_if;
   logic                          valid;
   logic                          ready;
   logic [ept_pkg::OP_W-1:0]      operation;
   logic [ept_pkg::DEV_W-1:0]     dev_id;
   logic [ept_pkg::TIME_W-1:0]    now_ms;
   logic [ept_pkg::TIME_W-1:0]    now_us;
   logic [ept_pkg::SEQ_W-1:0]     reply_seq;

   modport source (output valid, output operation, output dev_id, output now_ms,
                   output now_us, output reply_seq, input ready);
   modport sink (input valid, input operation, input dev_id, input now_ms,
                 input now_us, input reply_seq, output ready);
endinterface

FILE: sv/ept_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries one event word per run concerned, flagged last on the final one.
// ----------------------------------------------------------------------------
interface ept_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ept_pkg::KIND_W-1:0]    kind;
   logic [ept_pkg::DEV_W-1:0]     run_dev;
   logic [ept_pkg::LOST_W-1:0]    lost_count;
   logic                          probe_sent;
   logic [ept_pkg::SEQ_W-1:0]     probe_seq;
   logic [ept_pkg::RTT_W-1:0]     rtt_us;
   logic                          last;

   modport source (output valid, output kind, output run_dev, output lost_count,
                   output probe_sent, output probe_seq, output rtt_us, output last,
                   input ready);
   modport sink (input valid, input kind, input run_dev, input lost_count,
                 input probe_sent, input probe_seq, input rtt_us, input last,
                 output ready);
endinterface

FILE: sv/ept_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register write channel
// Carries a register index and its write data.
// ----------------------------------------------------------------------------
interface ept_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ept_pkg::CSR_IDX_W-1:0]   index;
   logic [ept_pkg::MS_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/echo_probe_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo probe tracker
// Run table and probe slot table held in synchronous memories, walked by a
// sequencer that reads, updates and writes back one entry per cycle.
// ----------------------------------------------------------------------------
//  Channel    Direction  Word
//  req_chan   in         operation, dev_id, now_ms, now_us, reply_seq
//  rsp_chan   out        kind, run_dev, lost_count, probe_sent, probe_seq,
//                        rtt_us, last
//  csr_chan   in         index, data (0 interval_ms, 1 timeout_ms)
//
// One command at a time. A tick streams each run's slots through the slot
// memory read port. A toggle searches the runs, stops the one found (moving
// the last run into its place) or else starts one if not full; a reply
// scans slots until one matches. A stalled response holds the sequencer,
// but the final word of a command waits in the output register while the
// next command is taken. Synchronous reset empties the run table at once.
// ----------------------------------------------------------------------------
module echo_probe_tracker_top #(
   parameter int RUNS  = ept_pkg::RUNS_DEF,
   parameter int SLOTS = ept_pkg::SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ept_req_if.sink      req_chan,
   ept_rsp_if.source    rsp_chan,
   ept_csr_if.sink      csr_chan
);

   localparam int RW  = $clog2(RUNS + 1);
   localparam int RA  = (RUNS > 1) ? $clog2(RUNS) : 1;
   localparam int SC  = $clog2(SLOTS + 1);
   localparam int SA  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLA = (RUNS * SLOTS > 1) ? $clog2(RUNS * SLOTS) : 1;
   localparam int LW  = ($clog2(SLOTS + 2) > 4) ? $clog2(SLOTS + 2) : 4;
   localparam int TW  = ept_pkg::TIME_W;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_TG_SCAN = 4'd1;
   localparam logic [3:0] ST_CP      = 4'd2;
   localparam logic [3:0] ST_DR_EMIT = 4'd3;
   localparam logic [3:0] ST_SA_RD   = 4'd4;
   localparam logic [3:0] ST_SA_GET  = 4'd5;
   localparam logic [3:0] ST_TK_RUN  = 4'd6;
   localparam logic [3:0] ST_TK_SLOT = 4'd7;
   localparam logic [3:0] ST_TK_SEND = 4'd8;
   localparam logic [3:0] ST_RP_SCAN = 4'd9;
   localparam logic [3:0] ST_RP_DEV  = 4'd10;
   localparam logic [3:0] ST_RP_EMIT = 4'd11;

   logic [3:0]      state_ff, state_in;
   logic [RW-1:0]   count_ff, count_in;
   logic [RW-1:0]   ridx_ff, ridx_in;
   logic [SC-1:0]   sidx_ff, sidx_in;
   logic            pvalid_ff, pvalid_in;
   logic [RA-1:0]   prun_ff, prun_in;
   logic [SA-1:0]   pslot_ff, pslot_in;
   logic [RA-1:0]   hit_ff, hit_in;
   logic [3:0]      window_ff, window_in;
   logic [15:0]     interval_ff, timeout_ff;
   logic [LW-1:0]   lost_ff, lost_in;
   logic            free_ff, free_in;
   logic [SA-1:0]   free_idx_ff, free_idx_in;
   logic [SA-1:0]   best_idx_ff, best_idx_in;
   logic [TW-1:0]   best_stamp_ff, best_stamp_in;
   logic [31:0]     rtt_ff, rtt_in;
   logic [15:0]     dev_ff, dev_in;
   logic [1:0]      op_ff;
   logic [TW-1:0]   nms_ff, nus_ff;
   logic [15:0]     rseq_ff;
   logic [ept_pkg::LIMIT_W-1:0] limit_ff;
   logic [RUNS-1:0][SLOTS-1:0] used_ff, used_in;

   ept_pkg::run_entry_type  run_mem [RUNS];
   ept_pkg::run_entry_type  run_rdata_ff, run_wdata;
   logic                    run_re, run_we;
   logic [RA-1:0]           run_raddr, run_waddr;

   ept_pkg::slot_entry_type slot_mem [RUNS*SLOTS];
   ept_pkg::slot_entry_type slot_rdata_ff, slot_wdata;
   logic                    slot_re, slot_we;
   logic [SLA-1:0]          slot_raddr, slot_waddr;

   ept_pkg::rsp_word_type   rsp_ff, emit_word;
   logic                    rsp_valid_ff, rsp_valid_in, emit;

   logic            req_take, can_emit;
   logic [RW-1:0]   count_m1, ridx_p1;
   logic [RA-1:0]   t_idx, cur_run;
   logic [TW-1:0]   age;
   logic            timed_out, dev_match, seq_match, due_now;
   logic [TW:0]     due_sum;
   logic [TW-1:0]   due_next;
   logic [SA-1:0]   pick;
   logic [LW-1:0]   lost_tot;
   logic            used_bit;

   function automatic logic [SLA-1:0] slot_addr(input logic [RA-1:0] r,
                                                input logic [SA-1:0] s);
      slot_addr = SLA'(SLA'(r) * SLA'(SLOTS)) + SLA'(s);
   endfunction

   function automatic logic [ept_pkg::LOST_W-1:0] lost_sat(input logic [LW-1:0] v);
      lost_sat = (v > LW'(15)) ? 4'd15 : v[3:0];
   endfunction

   assign req_take      = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign can_emit      = !rsp_valid_ff || rsp_chan.ready;

   assign count_m1  = count_ff - RW'(1);
   assign ridx_p1   = ridx_ff + RW'(1);
   assign t_idx     = count_m1[RA-1:0];
   assign cur_run   = ridx_ff[RA-1:0];
   assign age       = nus_ff - slot_rdata_ff.stamp;
   assign timed_out = age > TW'(limit_ff);
   assign dev_match = (run_rdata_ff.dev == dev_ff);
   assign seq_match = (slot_rdata_ff.seq == rseq_ff);
   assign due_now   = ({1'b0, nms_ff} + (TW+1)'(1)) >= {1'b0, run_rdata_ff.due};
   assign due_sum   = {1'b0, nms_ff} + (TW+1)'(interval_ff);
   assign due_next  = due_sum[TW] ? {TW{1'b1}} : due_sum[TW-1:0];
   assign pick      = free_ff ? free_idx_ff : best_idx_ff;
   assign lost_tot  = lost_ff + LW'(due_now && !free_ff);
   assign used_bit  = used_ff[prun_ff][pslot_ff];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ridx_in       = ridx_ff;
      sidx_in       = sidx_ff;
      pvalid_in     = 1'b0;
      prun_in       = prun_ff;
      pslot_in      = pslot_ff;
      hit_in        = hit_ff;
      window_in     = window_ff;
      lost_in       = lost_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      rtt_in        = rtt_ff;
      dev_in        = dev_ff;
      used_in       = used_ff;
      run_re        = 1'b0;
      run_raddr     = cur_run;
      run_we        = 1'b0;
      run_waddr     = cur_run;
      run_wdata     = run_rdata_ff;
      slot_re       = 1'b0;
      slot_raddr    = slot_addr(cur_run, sidx_ff[SA-1:0]);
      slot_we       = 1'b0;
      slot_waddr    = slot_addr(hit_ff, pslot_ff);
      slot_wdata    = slot_rdata_ff;
      emit          = 1'b0;
      emit_word     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               dev_in  = req_chan.dev_id;
               ridx_in = '0;
               sidx_in = '0;
               case (req_chan.operation)
                  ept_pkg::OP_TOGGLE: state_in = ST_TG_SCAN;
                  ept_pkg::OP_STOP:   state_in = (count_ff != '0) ? ST_SA_RD : ST_IDLE;
                  ept_pkg::OP_TICK:   state_in = (count_ff != '0) ? ST_TK_RUN : ST_IDLE;
                  default:            state_in = (count_ff != '0) ? ST_RP_SCAN : ST_IDLE;
               endcase
            end
         end

         ST_TG_SCAN: begin
            if (ridx_ff < count_ff) begin
               run_re    = 1'b1;
               run_raddr = cur_run;
               ridx_in   = ridx_p1;
               pvalid_in = 1'b1;
               prun_in   = cur_run;
            end
            if (pvalid_ff && dev_match) begin
               hit_in   = prun_ff;
               lost_in  = LW'($countones(used_ff[prun_ff]));
               sidx_in  = '0;
               pvalid_in = 1'b0;
               state_in = (prun_ff == t_idx) ? ST_DR_EMIT : ST_CP;
            end else if (ridx_ff == count_ff && can_emit) begin
               emit = 1'b1;
               emit_word.run_dev = dev_ff;
               emit_word.last    = 1'b1;
               if (count_ff >= RW'(RUNS)) begin
                  emit_word.kind = ept_pkg::KIND_FULL;
               end else begin
                  emit_word.kind = ept_pkg::KIND_STARTED;
                  run_we    = 1'b1;
                  run_waddr = count_ff[RA-1:0];
                  run_wdata = '{dev: dev_ff, win: window_ff, off: '0, due: nms_ff};
                  used_in[count_ff[RA-1:0]] = '0;
                  window_in = window_ff + 4'd1;
                  count_in  = count_ff + RW'(1);
               end
               state_in = ST_IDLE;
            end
         end

         // Move the last run into the hole, one slot word per cycle.
         ST_CP: begin
            if (sidx_ff < SC'(SLOTS)) begin
               slot_re    = 1'b1;
               slot_raddr = slot_addr(t_idx, sidx_ff[SA-1:0]);
               run_re     = (sidx_ff == '0);
               run_raddr  = t_idx;
               sidx_in    = sidx_ff + SC'(1);
               pvalid_in  = 1'b1;
               pslot_in   = sidx_ff[SA-1:0];
            end
            if (pvalid_ff) begin
               slot_we    = 1'b1;
               slot_waddr = slot_addr(hit_ff, pslot_ff);
               slot_wdata = slot_rdata_ff;
               if (pslot_ff == '0) begin
                  run_we    = 1'b1;
                  run_waddr = hit_ff;
                  run_wdata = run_rdata_ff;
               end
               if (pslot_ff == SA'(SLOTS - 1)) begin
                  state_in = ST_DR_EMIT;
               end
            end
         end

         ST_DR_EMIT: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_word.kind       = ept_pkg::KIND_STOPPED;
               emit_word.run_dev    = dev_ff;
               emit_word.lost_count = lost_sat(lost_ff);
               emit_word.last       = (op_ff != ept_pkg::OP_STOP) || (count_m1 == '0);
               used_in[hit_ff] = used_ff[t_idx];
               count_in = count_m1;
               state_in = (op_ff == ept_pkg::OP_STOP && count_m1 != '0) ? ST_SA_RD : ST_IDLE;
            end
         end

         ST_SA_RD: begin
            run_re    = 1'b1;
            run_raddr = t_idx;
            state_in  = ST_SA_GET;
         end

         ST_SA_GET: begin
            dev_in   = run_rdata_ff.dev;
            lost_in  = LW'($countones(used_ff[t_idx]));
            hit_in   = t_idx;
            state_in = ST_DR_EMIT;
         end

         ST_TK_RUN: begin
            run_re     = 1'b1;
            run_raddr  = cur_run;
            slot_re    = 1'b1;
            slot_raddr = slot_addr(cur_run, '0);
            sidx_in    = SC'(1);
            pvalid_in  = 1'b1;
            pslot_in   = '0;
            prun_in    = cur_run;
            lost_in    = '0;
            free_in    = 1'b0;
            state_in   = ST_TK_SLOT;
         end

         // Age out slots and find the first free and the oldest slot.
         ST_TK_SLOT: begin
            if (sidx_ff < SC'(SLOTS)) begin
               slot_re    = 1'b1;
               slot_raddr = slot_addr(cur_run, sidx_ff[SA-1:0]);
               sidx_in    = sidx_ff + SC'(1);
               pvalid_in  = 1'b1;
               pslot_in   = sidx_ff[SA-1:0];
            end
            if (pvalid_ff) begin
               if (used_bit && timed_out) begin
                  used_in[cur_run][pslot_ff] = 1'b0;
                  lost_in = lost_ff + LW'(1);
               end
               if ((!used_bit || timed_out) && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pslot_ff;
               end
               if (pslot_ff == '0 || slot_rdata_ff.stamp < best_stamp_ff) begin
                  best_idx_in   = pslot_ff;
                  best_stamp_in = slot_rdata_ff.stamp;
               end
               if (pslot_ff == SA'(SLOTS - 1)) begin
                  state_in = ST_TK_SEND;
               end
            end
         end

         ST_TK_SEND: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_word.kind       = ept_pkg::KIND_TICK;
               emit_word.run_dev    = run_rdata_ff.dev;
               emit_word.lost_count = lost_sat(lost_tot);
               emit_word.last       = (ridx_p1 == count_ff);
               if (due_now) begin
                  emit_word.probe_sent = 1'b1;
                  emit_word.probe_seq  = {run_rdata_ff.win, run_rdata_ff.off};
                  slot_we    = 1'b1;
                  slot_waddr = slot_addr(cur_run, pick);
                  slot_wdata = '{seq: {run_rdata_ff.win, run_rdata_ff.off}, stamp: nus_ff};
                  used_in[cur_run][pick] = 1'b1;
                  run_we    = 1'b1;
                  run_waddr = cur_run;
                  run_wdata = '{dev: run_rdata_ff.dev, win: run_rdata_ff.win,
                                off: run_rdata_ff.off + 12'd1, due: due_next};
               end
               ridx_in  = ridx_p1;
               state_in = (ridx_p1 < count_ff) ? ST_TK_RUN : ST_IDLE;
            end
         end

         ST_RP_SCAN: begin
            if (ridx_ff < count_ff) begin
               slot_re    = 1'b1;
               slot_raddr = slot_addr(cur_run, sidx_ff[SA-1:0]);
               pvalid_in  = 1'b1;
               prun_in    = cur_run;
               pslot_in   = sidx_ff[SA-1:0];
               if (sidx_ff == SC'(SLOTS - 1)) begin
                  sidx_in = '0;
                  ridx_in = ridx_p1;
               end else begin
                  sidx_in = sidx_ff + SC'(1);
               end
            end
            if (pvalid_ff && used_bit && seq_match) begin
               used_in[prun_ff][pslot_ff] = 1'b0;
               hit_in   = prun_ff;
               rtt_in   = (age[TW-1:32] != '0) ? 32'hFFFF_FFFF : age[31:0];
               state_in = ST_RP_DEV;
            end else if (ridx_ff == count_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_RP_DEV: begin
            run_re    = 1'b1;
            run_raddr = hit_ff;
            state_in  = ST_RP_EMIT;
         end

         ST_RP_EMIT: begin
            if (can_emit) begin
               emit = 1'b1;
               emit_word.kind    = ept_pkg::KIND_REPLY;
               emit_word.run_dev = run_rdata_ff.dev;
               emit_word.rtt_us  = rtt_ff;
               emit_word.last    = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         window_ff    <= '0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         interval_ff  <= ept_pkg::INTERVAL_RST;
         timeout_ff   <= ept_pkg::TIMEOUT_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         window_ff    <= window_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == ept_pkg::CSR_INTERVAL) begin
               interval_ff <= csr_chan.data;
            end else if (csr_chan.index == ept_pkg::CSR_TIMEOUT) begin
               timeout_ff <= csr_chan.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff       <= ridx_in;
      sidx_ff       <= sidx_in;
      prun_ff       <= prun_in;
      pslot_ff      <= pslot_in;
      hit_ff        <= hit_in;
      lost_ff       <= lost_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      rtt_ff        <= rtt_in;
      dev_ff        <= dev_in;
      if (emit) begin
         rsp_ff <= emit_word;
      end
      if (req_take) begin
         op_ff    <= req_chan.operation;
         nms_ff   <= req_chan.now_ms;
         nus_ff   <= req_chan.now_us;
         rseq_ff  <= req_chan.reply_seq;
         limit_ff <= ept_pkg::LIMIT_W'(ept_pkg::LIMIT_W'(timeout_ff) * ept_pkg::US_PER_MS);
      end
   end

   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[run_waddr] <= run_wdata;
      end
      if (run_re) begin
         run_rdata_ff <= run_mem[run_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_rdata_ff <= slot_mem[slot_raddr];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_ff.kind;
   assign rsp_chan.run_dev    = rsp_ff.run_dev;
   assign rsp_chan.lost_count = rsp_ff.lost_count;
   assign rsp_chan.probe_sent = rsp_ff.probe_sent;
   assign rsp_chan.probe_seq  = rsp_ff.probe_seq;
   assign rsp_chan.rtt_us     = rsp_ff.rtt_us;
   assign rsp_chan.last       = rsp_ff.last;

   // The run table never holds more runs than it has rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RW'(RUNS))
      else $error("run count above table size");

   // The run count moves by at most one per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + RW'(1) || count_ff == $past(count_ff) - RW'(1)))
      else $error("run count jumped");

   // Loading the final word of a command returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_word.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after final word");

endmodule
